// File: design/atan2_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package atan2_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int DEN_W      = SAMPLE_W + 1;
    localparam int REM_W      = SAMPLE_W + 2;
    localparam int NUM_W      = SAMPLE_W + 2;
    localparam int M_W        = 16;
    localparam int DIV_STAGES = 4;
    localparam int DIV_STEPS  = M_W / DIV_STAGES;
    localparam int ANG_W      = 16;
    localparam int TDATA_IN_W = ((2 * SAMPLE_W + 7) / 8) * 8;
    localparam int TDATA_OUT_W = ((ANG_W + 7) / 8) * 8;

    // prep, divider stages, round, two multiply stages, poly, output
    localparam int NSTAGE = DIV_STAGES + 6;
    localparam int ST_ROUND = DIV_STAGES + 1;
    localparam int ST_MUL1  = DIV_STAGES + 2;
    localparam int ST_MUL2  = DIV_STAGES + 3;
    localparam int ST_POLY  = DIV_STAGES + 4;
    localparam int ST_OUT   = DIV_STAGES + 5;

    localparam int C3_W = 13;
    localparam int C1_W = 15;
    localparam logic [C3_W-1:0] COEF_C3 = 13'd6432;
    localparam logic [C1_W-1:0] COEF_C1 = 15'd32168;

    localparam int M2_W  = 2 * M_W;
    localparam int C3M_W = C3_W + M_W;
    localparam int LIN_W = C1_W + M_W;
    localparam int T_W   = C3M_W + M2_W;
    localparam int G_W   = LIN_W + 30;
    localparam int P_W   = G_W - 47;

    localparam logic signed [ANG_W-1:0] ANG_PI_4  = 16'sd6434;
    localparam logic signed [ANG_W-1:0] ANG_3PI_4 = 16'sd19302;
    localparam logic signed [ANG_W-1:0] ANG_PI    = 16'sd25736;

    typedef struct packed {
        logic y_neg;
        logic x_neg;
        logic zero;
        logic r_neg;
    } ctl_t;

endpackage

`default_nettype wire

// File: design/atan2_cubic_approx_unit.sv
// throughput: one item per cycle while m_tready is high or a stage is empty,
// set by the fully pipelined divider and multipliers
// stalls collapse bubbles stage by stage, so input is taken while empty stages remain
// reset: synchronous active-low aresetn clears all stage valid bits and holds s_tready low
// data registers are not reset
`timescale 1ns / 1ps
`default_nettype none

module atan2_cubic_approx_unit (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [atan2_pkg::TDATA_IN_W-1:0]       s_tdata,  // y_value, x_value
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [atan2_pkg::TDATA_OUT_W-1:0]           m_tdata   // angle
);

    localparam int N = atan2_pkg::NSTAGE;
    localparam int W = atan2_pkg::SAMPLE_W;
    localparam int D = atan2_pkg::DIV_STAGES;

    logic                                vld_reg [0:N-1];
    logic                                adv     [0:N-1];
    atan2_pkg::ctl_t                     ctl_reg [0:N-2];
    logic [atan2_pkg::REM_W-1:0]         div_r_reg  [0:D];
    logic [atan2_pkg::REM_W-1:0]         div_r_next [1:D];
    logic [atan2_pkg::M_W-1:0]           div_q_reg  [0:D];
    logic [atan2_pkg::M_W-1:0]           div_q_next [1:D];
    logic [atan2_pkg::DEN_W-1:0]         den_reg    [0:D];

    logic [atan2_pkg::M_W-1:0]           m_reg;
    logic [atan2_pkg::M_W-1:0]           m_next;
    logic [atan2_pkg::M2_W-1:0]          m2_reg;
    logic [atan2_pkg::C3M_W-1:0]         c3m_reg;
    logic [atan2_pkg::LIN_W-1:0]         lin1_reg;
    logic [atan2_pkg::T_W-1:0]           t_reg;
    logic [atan2_pkg::LIN_W-1:0]         lin2_reg;
    logic [atan2_pkg::P_W-1:0]           p_reg;
    logic [atan2_pkg::P_W-1:0]           p_next;
    logic signed [atan2_pkg::ANG_W-1:0]  angle_reg;
    logic signed [atan2_pkg::ANG_W-1:0]  angle_next;

    // prep stage signals
    logic signed [W-1:0]                 y_in;
    logic signed [W-1:0]                 x_in;
    logic signed [atan2_pkg::NUM_W-1:0]  ys;
    logic signed [atan2_pkg::NUM_W-1:0]  xs;
    logic signed [atan2_pkg::NUM_W-1:0]  ays;
    logic signed [atan2_pkg::NUM_W-1:0]  num;
    logic signed [atan2_pkg::NUM_W-1:0]  den_s;
    logic signed [atan2_pkg::NUM_W-1:0]  mnum_s;
    atan2_pkg::ctl_t                     ctl_next;

    // handshake and bubble collapse
    always_comb begin
        adv[N-1] = !vld_reg[N-1] || m_tready;
        for (int k = N - 2; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign s_tready = adv[0] && aresetn;
    assign m_tvalid = vld_reg[N-1];
    assign m_tdata  = atan2_pkg::TDATA_OUT_W'(angle_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < N; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < N; k++) begin
                if (adv[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // prep: ratio numerator and denominator
    always_comb begin
        y_in  = s_tdata[W-1:0];
        x_in  = s_tdata[2*W-1:W];
        ys    = atan2_pkg::NUM_W'(y_in);
        xs    = atan2_pkg::NUM_W'(x_in);
        ays   = y_in[W-1] ? -ys : ys;
        if (!x_in[W-1]) begin
            num   = xs - ays;
            den_s = xs + ays;
        end else begin
            num   = xs + ays;
            den_s = ays - xs;
        end
        mnum_s         = num[atan2_pkg::NUM_W-1] ? -num : num;
        ctl_next.y_neg = y_in[W-1];
        ctl_next.x_neg = x_in[W-1];
        ctl_next.zero  = (y_in == '0) && (x_in == '0);
        ctl_next.r_neg = num[atan2_pkg::NUM_W-1];
    end

    // restoring divider, four quotient bits (DIV_STEPS) per stage
    always_comb begin
        logic [atan2_pkg::REM_W-1:0] r;
        logic [atan2_pkg::M_W-1:0]   q;
        logic                        qb;
        for (int k = 1; k <= D; k++) begin
            r = div_r_reg[k-1];
            q = div_q_reg[k-1];
            for (int s = 0; s < atan2_pkg::DIV_STEPS; s++) begin
                qb = (r >= atan2_pkg::REM_W'(den_reg[k-1]));
                if (qb) begin
                    r = r - atan2_pkg::REM_W'(den_reg[k-1]);
                end
                r = {r[atan2_pkg::REM_W-2:0], 1'b0};
                q = {q[atan2_pkg::M_W-2:0], qb};
            end
            div_r_next[k] = r;
            div_q_next[k] = q;
        end
    end

    // round half up, then polynomial tail
    always_comb begin
        logic [atan2_pkg::G_W-1:0] g;
        m_next = div_q_reg[D]
               + atan2_pkg::M_W'(div_r_reg[D] >= atan2_pkg::REM_W'(den_reg[D]));
        g      = {lin2_reg, 30'b0} - atan2_pkg::G_W'(t_reg)
               + (atan2_pkg::G_W'(1) << 46);
        p_next = g[atan2_pkg::G_W-1:47];
    end

    always_comb begin
        logic signed [atan2_pkg::ANG_W-1:0] off;
        logic signed [atan2_pkg::ANG_W-1:0] p_s;
        logic signed [atan2_pkg::ANG_W-1:0] a;
        off = ctl_reg[N-2].x_neg ? atan2_pkg::ANG_3PI_4 : atan2_pkg::ANG_PI_4;
        p_s = atan2_pkg::ANG_W'(p_reg);
        a   = ctl_reg[N-2].r_neg ? (off + p_s) : (off - p_s);
        if (ctl_reg[N-2].y_neg) begin
            a = -a;
        end
        if (ctl_reg[N-2].zero) begin
            a = atan2_pkg::ANG_PI;
        end
        angle_next = a;
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            ctl_reg[0]   <= ctl_next;
            div_r_reg[0] <= atan2_pkg::REM_W'(mnum_s[atan2_pkg::DEN_W-1:0]);
            div_q_reg[0] <= '0;
            den_reg[0]   <= den_s[atan2_pkg::DEN_W-1:0];
        end
        for (int k = 1; k <= D; k++) begin
            if (adv[k]) begin
                div_r_reg[k] <= div_r_next[k];
                div_q_reg[k] <= div_q_next[k];
                den_reg[k]   <= den_reg[k-1];
            end
        end
        for (int k = 1; k < N - 1; k++) begin
            if (adv[k]) begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
        if (adv[atan2_pkg::ST_ROUND]) begin
            m_reg <= m_next;
        end
        if (adv[atan2_pkg::ST_MUL1]) begin
            m2_reg   <= m_reg * m_reg;
            c3m_reg  <= atan2_pkg::C3M_W'(atan2_pkg::COEF_C3) * atan2_pkg::C3M_W'(m_reg);
            lin1_reg <= atan2_pkg::LIN_W'(atan2_pkg::COEF_C1) * atan2_pkg::LIN_W'(m_reg);
        end
        if (adv[atan2_pkg::ST_MUL2]) begin
            t_reg    <= atan2_pkg::T_W'(c3m_reg) * atan2_pkg::T_W'(m2_reg);
            lin2_reg <= lin1_reg;
        end
        if (adv[atan2_pkg::ST_POLY]) begin
            p_reg <= p_next;
        end
        if (adv[atan2_pkg::ST_OUT]) begin
            angle_reg <= angle_next;
        end
    end

endmodule

`default_nettype wire
